// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst_n is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ped_pkg.sv -----
package ped_pkg;

  localparam int unsigned LIMIT_W     = 13;
  localparam int unsigned MAX_OUT     = 4096;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_OUT);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
  localparam logic [7:0]         PCT_CHAR    = 8'h25;

  // Escape tracking codes
  localparam logic [1:0] HC_NONE = 2'd0;
  localparam logic [1:0] HC_PCT  = 2'd1;
  localparam logic [1:0] HC_DIG  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
  } out_t;

  // Return {is_hex, nibble} for one character, either case.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/percent_escape_decoder.sv -----
// Each input item's results are registered into the result queue when the item is accepted.
// Throughput: one input item per cycle while each yields at most one result and out_stall is low;
// an item yielding two or three results stalls the input until the single output port
// has drained the four-slot result queue down to one entry.
// Reset (rst_n low, synchronous): queue empty, no escape held, count zero, limit 4096.
`include "assert_macros.svh"

module percent_escape_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ped_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ped_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ped_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam int unsigned DEPTH = 4;

  logic [ped_pkg::LIMIT_W-1:0] limit_r;
  logic [ped_pkg::LIMIT_W-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [1:0]                  held_cnt_r, held_cnt_nxt;
  logic [7:0]                  held1_r, held1_nxt;
  ped_pkg::out_t               q_r [DEPTH];
  ped_pkg::out_t               q_nxt [DEPTH];
  ped_pkg::out_t               q_sh [DEPTH];
  logic [2:0]                  cnt_r, cnt_nxt;

  logic                        accept, pop;
  logic [7:0]                  b;
  logic                        b_pct;
  logic [4:0]                  b_hex, h_hex;
  logic [7:0]                  cand [3];
  logic [2:0]                  nc;
  logic [1:0]                  hc_new;
  logic [7:0]                  h1_new;
  logic [ped_pkg::LIMIT_W-1:0] lim, room;
  logic [1:0]                  k;
  logic [1:0]                  m;
  ped_pkg::out_t               res [3];
  logic [2:0]                  base;
  logic [2:0]                  j3;

  assign cfg_ready = 1'b1;
  assign in_stall  = (cnt_r > 3'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;

  assign b     = in_data.in_byte;
  assign b_pct = (b == ped_pkg::PCT_CHAR);
  assign b_hex = ped_pkg::hex_value(b);
  assign h_hex = ped_pkg::hex_value(held1_r);

  // Scan the byte against the held escape and list the candidate bytes
  always_comb begin
    cand[0] = 8'h00;
    cand[1] = 8'h00;
    cand[2] = 8'h00;
    nc      = 3'd0;
    hc_new  = held_cnt_r;
    h1_new  = held1_r;
    unique case (held_cnt_r)
      ped_pkg::HC_NONE: begin
        if (b_pct) begin
          hc_new = ped_pkg::HC_PCT;
        end else begin
          cand[0] = b;
          nc      = 3'd1;
        end
      end
      ped_pkg::HC_PCT: begin
        if (b_hex[4]) begin
          hc_new = ped_pkg::HC_DIG;
          h1_new = b;
        end else if (b_pct) begin
          cand[0] = ped_pkg::PCT_CHAR;
          nc      = 3'd1;
        end else begin
          cand[0] = ped_pkg::PCT_CHAR;
          cand[1] = b;
          nc      = 3'd2;
          hc_new  = ped_pkg::HC_NONE;
        end
      end
      ped_pkg::HC_DIG: begin
        if (b_hex[4] && h_hex[4]) begin
          cand[0] = {h_hex[3:0], b_hex[3:0]};
          nc      = 3'd1;
          hc_new  = ped_pkg::HC_NONE;
        end else if (b_pct) begin
          cand[0] = ped_pkg::PCT_CHAR;
          cand[1] = held1_r;
          nc      = 3'd2;
          hc_new  = ped_pkg::HC_PCT;
        end else begin
          cand[0] = ped_pkg::PCT_CHAR;
          cand[1] = held1_r;
          cand[2] = b;
          nc      = 3'd3;
          hc_new  = ped_pkg::HC_NONE;
        end
      end
      default: begin
        hc_new = ped_pkg::HC_NONE;
      end
    endcase
    // Flush a pending escape at the end of the string; keep at most three
    if (in_data.in_last) begin
      if (hc_new != ped_pkg::HC_NONE && nc < 3'd3) begin
        cand[nc[1:0]] = ped_pkg::PCT_CHAR;
        nc            = nc + 3'd1;
      end
      if (hc_new == ped_pkg::HC_DIG) begin
        cand[1] = h1_new;
        nc      = 3'd2;
      end
    end
  end

  // Clip the count of emitted bytes to the per-string limit
  always_comb begin
    lim  = (limit_r > ped_pkg::LIMIT_MAX) ? ped_pkg::LIMIT_MAX : limit_r;
    room = (emit_cnt_r < lim) ? (lim - emit_cnt_r) : '0;
    if (room < ped_pkg::LIMIT_W'(nc)) begin
      k = room[1:0];
    end else begin
      k = nc[1:0];
    end
  end

  // Form the result items of this input item
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      res[r].out_byte    = cand[r];
      res[r].byte_valid  = 1'b1;
      res[r].run_last    = (2'(r) == k - 2'd1);
      res[r].string_done = in_data.in_last && (2'(r) == k - 2'd1);
    end
    m = k;
    if (k == 2'd0 && in_data.in_last) begin
      res[0].out_byte    = 8'h00;
      res[0].byte_valid  = 1'b0;
      res[0].run_last    = 1'b1;
      res[0].string_done = 1'b1;
      m                  = 2'd1;
    end
    if (!accept) begin
      m = 2'd0;
    end
  end

  // Shift out the taken item and append the new results behind the rest
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      q_sh[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_sh[DEPTH-1] = q_r[DEPTH-1];
    base = cnt_r - {2'b00, pop};
    for (int i = 0; i < DEPTH; i++) begin
      j3       = 3'(i) - base;
      q_nxt[i] = q_sh[i];
      if (3'(i) >= base && j3 < {1'b0, m}) begin
        q_nxt[i] = res[j3[1:0]];
      end
    end
    cnt_nxt = base + {1'b0, m};
  end

  // Advance the escape and count state on an accepted item
  always_comb begin
    held_cnt_nxt = held_cnt_r;
    held1_nxt    = held1_r;
    emit_cnt_nxt = emit_cnt_r;
    if (accept) begin
      if (in_data.in_last) begin
        held_cnt_nxt = ped_pkg::HC_NONE;
        held1_nxt    = 8'h00;
        emit_cnt_nxt = '0;
      end else begin
        held_cnt_nxt = hc_new;
        held1_nxt    = h1_new;
        emit_cnt_nxt = emit_cnt_r + ped_pkg::LIMIT_W'(k);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= 3'd0;
      held_cnt_r <= ped_pkg::HC_NONE;
      emit_cnt_r <= '0;
      limit_r    <= ped_pkg::LIMIT_RESET;
    end else begin
      cnt_r      <= cnt_nxt;
      held_cnt_r <= held_cnt_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held1_r <= held1_nxt;
    for (int i = 0; i < DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_r <= 3'(DEPTH), "result queue overfilled")
  `ASSERT_CLK(a_room_on_accept, accept |-> cnt_r <= 3'd1, "item taken without queue room")
  `ASSERT_CLK(a_done_is_last, (out_valid && out_data.string_done) |-> out_data.run_last,
              "string_done without run_last")
  `ASSERT_CLK(a_empty_closes, (out_valid && !out_data.byte_valid) |-> out_data.string_done,
              "empty result that does not close a string")
  `ASSERT_CLK(a_last_clears, (accept && in_data.in_last) |=> emit_cnt_r == '0,
              "emitted count not cleared after final item")

endmodule

// ----- dv/percent_escape_decoder_tb.sv -----
`timescale 1ns / 1ps

module percent_escape_decoder_tb;

  localparam int ITEM_TARGET    = 100;
  localparam int QUIET_TAIL     = 30;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  typedef logic [7:0] byte_q_t[$];

  // Track the escape state and limit, and hold the decoded items still owed
  class decode_scoreboard;
    logic [ped_pkg::LIMIT_W-1:0] limit;
    logic [1:0]                  held_count;
    logic [7:0]                  held_digit;
    int unsigned                 emitted;
    logic [7:0]                  run_bytes[$];
    ped_pkg::out_t               expected_results[$];
    int                          errors;

    function new();
      limit      = ped_pkg::LIMIT_RESET;
      held_count = ped_pkg::HC_NONE;
      held_digit = 8'h00;
      emitted    = 0;
      errors     = 0;
    endfunction

    static function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
    endfunction

    function void set_limit(logic [ped_pkg::LIMIT_W-1:0] value);
      limit = value;
    endfunction

    // Emit one decoded byte unless the string already hit its limit or the run holds three
    function void push_byte(logic [7:0] b);
      int unsigned cap;
      cap = (limit > ped_pkg::MAX_OUT) ? ped_pkg::MAX_OUT : limit;
      if (emitted < cap && run_bytes.size() < 3) begin
        run_bytes.push_back(b);
        emitted++;
      end
    endfunction

    function void scan_plain(logic [7:0] b);
      if (b == ped_pkg::PCT_CHAR) begin
        held_count = ped_pkg::HC_PCT;
      end else begin
        held_count = ped_pkg::HC_NONE;
        push_byte(b);
      end
    endfunction

    function void note_input(ped_pkg::in_t item);
      logic [7:0] b;
      int lo;
      int hi;
      ped_pkg::out_t r;
      b = item.in_byte;
      run_bytes.delete();
      case (held_count)
        ped_pkg::HC_PCT: begin
          if (digit_value(b) >= 0) begin
            held_digit = b;
            held_count = ped_pkg::HC_DIG;
          end else begin
            push_byte(ped_pkg::PCT_CHAR);
            scan_plain(b);
          end
        end
        ped_pkg::HC_DIG: begin
          lo = digit_value(b);
          hi = digit_value(held_digit);
          if (lo >= 0 && hi >= 0) begin
            held_count = ped_pkg::HC_NONE;
            push_byte(8'((hi << 4) | lo));
          end else begin
            push_byte(ped_pkg::PCT_CHAR);
            push_byte(held_digit);
            scan_plain(b);
          end
        end
        default: begin
          scan_plain(b);
        end
      endcase

      // Flush a pending escape literally and clear the string state
      if (item.in_last) begin
        if (held_count != ped_pkg::HC_NONE) push_byte(ped_pkg::PCT_CHAR);
        if (held_count == ped_pkg::HC_DIG) push_byte(held_digit);
        held_count = ped_pkg::HC_NONE;
        held_digit = 8'h00;
        emitted    = 0;
      end

      for (int k = 0; k < run_bytes.size(); k++) begin
        r.out_byte    = run_bytes[k];
        r.byte_valid  = 1'b1;
        r.run_last    = (k == run_bytes.size() - 1);
        r.string_done = item.in_last && (k == run_bytes.size() - 1);
        expected_results.push_back(r);
      end
      if (item.in_last && run_bytes.size() == 0) begin
        r.out_byte    = 8'h00;
        r.byte_valid  = 1'b0;
        r.run_last    = 1'b1;
        r.string_done = 1'b1;
        expected_results.push_back(r);
      end
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("%0t: %s mismatch: expected 'h%0h, actual 'h%0h", $time, field, exp_v, act_v);
    endfunction

    function void check_result(ped_pkg::out_t got);
      ped_pkg::out_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, actual %p", $time, got);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.out_byte !== exp_r.out_byte) report("out_byte", exp_r.out_byte, got.out_byte);
      if (got.byte_valid !== exp_r.byte_valid)
        report("byte_valid", exp_r.byte_valid, got.byte_valid);
      if (got.run_last !== exp_r.run_last) report("run_last", exp_r.run_last, got.run_last);
      if (got.string_done !== exp_r.string_done)
        report("string_done", exp_r.string_done, got.string_done);
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  ped_pkg::in_t                in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  ped_pkg::out_t               out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [ped_pkg::LIMIT_W-1:0] cfg_data  = '0;

  decode_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  percent_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Note accepted input items and check accepted result items
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    if (quiet) stall_left = 0;
    out_stall <= (stall_left > 0);
  end

  // End the run when no handshake completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d items outstanding", $time,
               sb.expected_results.size());
      $display("** percent_escape_decoder: FAILED **");
      $finish;
    end
  end

  function automatic byte_q_t text_bytes(string txt);
    byte_q_t q;
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] random_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (decode_scoreboard::digit_value(b) >= 0);
    return b;
  endfunction

  // Build a string of escapes, broken escapes and raw bytes mixed together
  function automatic byte_q_t random_string();
    byte_q_t q;
    int target;
    target = $urandom_range(1, 10);
    while (q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: q.push_back(8'($urandom_range(0, 255)));
        3, 4, 5: begin
          q.push_back(ped_pkg::PCT_CHAR);
          q.push_back(random_digit());
          q.push_back(random_digit());
        end
        6: begin
          q.push_back(ped_pkg::PCT_CHAR);
          q.push_back(random_non_digit());
        end
        7: begin
          q.push_back(ped_pkg::PCT_CHAR);
          q.push_back(random_digit());
          q.push_back(random_non_digit());
        end
        8: q.push_back(ped_pkg::PCT_CHAR);
        default: begin
          q.push_back(ped_pkg::PCT_CHAR);
          q.push_back(random_digit());
        end
      endcase
    end
    return q;
  endfunction

  // Offer one item after an optional gap and hold it until accepted
  task automatic send_item(logic [7:0] b, logic last);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_string(byte_q_t s);
    foreach (s[i]) send_item(s[i], i == s.size() - 1);
  endtask

  // Drop valid, drain all results, then write the limit register
  task automatic write_limit(logic [ped_pkg::LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    byte_q_t s;
    int random_sent;
    int phase_items;
    int phase;
    logic [ped_pkg::LIMIT_W-1:0] lim;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings at the reset limit
    send_string('{8'h00, ped_pkg::PCT_CHAR, "4", "F", 8'hFF, ped_pkg::PCT_CHAR, "0", "0"});
    send_string(text_bytes("%g"));
    send_string(text_bytes("%4%4a"));
    send_string(text_bytes("%"));
    send_string(text_bytes("%B"));

    // Limit zero: only empty closing items
    write_limit(13'd0);
    send_string(text_bytes("ab"));

    // Limit above the maximum acts as the maximum
    write_limit(13'h1FFF);
    send_string(text_bytes("%7e"));

    // Limit reached before the final byte
    write_limit(13'd2);
    send_string(text_bytes("abc"));

    // Random phases over a spread of limits
    random_sent = 0;
    phase = 0;
    while (random_sent < ITEM_TARGET) begin
      case (phase % 7)
        0: lim = 13'd1;
        1: lim = 13'd3;
        2: lim = 13'd0;
        3: lim = 13'h1FFF;
        4: lim = 13'($urandom_range(1, 6));
        5: lim = 13'($urandom_range(0, 8191));
        default: lim = ped_pkg::LIMIT_RESET;
      endcase
      write_limit(lim);
      if (random_sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
      phase_items = 0;
      while (phase_items < 20) begin
        s = random_string();
        send_string(s);
        phase_items += s.size();
      end
      random_sent += phase_items;
      phase++;
    end

    // Drain and let the block settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("** percent_escape_decoder: PASSED **");
    end else begin
      if (sb.expected_results.size() != 0)
        $display("%0t: %0d expected items never arrived", $time, sb.expected_results.size());
      $display("** percent_escape_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ped_pkg.sv
rtl/percent_escape_decoder.sv
dv/percent_escape_decoder_tb.sv
